// File: hdl/voc_pkg.sv
// ----------------------------------------------------------------------------
// voc_pkg - shared types and constants
// Codes, widths and reset values for the voxel occupancy / free-space block.
// ----------------------------------------------------------------------------
`default_nettype none

package voc_pkg;

    // default grid geometry
    localparam int GRID_X_DEF = 64;
    localparam int GRID_Y_DEF = 64;
    localparam int GRID_Z_DEF = 32;

    // field widths
    localparam int CRD_W  = 24;   // coordinates, grid minimum
    localparam int PNT_W  = 16;   // point count
    localparam int SEEN_W = 32;   // free-space count
    localparam int SUM_W  = 52;   // sum of squared ray components
    localparam int LEN_W  = 24;   // ray length Q16.8
    localparam int NUM_W  = 40;   // |component| << 16
    localparam int UNIT_W = 18;   // unit vector Q2.16
    localparam int POS_W  = 42;   // ray position, Q.16 voxels
    localparam int STP_W  = 16;   // step count

    localparam int COMP_MAX = 16777215;
    localparam logic [15:0] FRAC_085  = 16'd55706;
    localparam logic [15:0] STEP_BIAS = 16'd3;

    // register reset values
    localparam logic [7:0] VPM_RST    = 8'd10;
    localparam logic [6:0] SIZE_X_RST = 7'd64;
    localparam logic [6:0] SIZE_Y_RST = 7'd64;
    localparam logic [5:0] SIZE_Z_RST = 6'd32;

    typedef enum logic [2:0] {
        REG_MIN_X,
        REG_MIN_Y,
        REG_MIN_Z,
        REG_VPM,
        REG_SIZE_X,
        REG_SIZE_Y,
        REG_SIZE_Z
    } t_reg;

    typedef enum logic [1:0] {
        MODE_POINT,
        MODE_CAST,
        MODE_READ,
        MODE_CLEAR
    } t_mode;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_PT_MUL,
        S_PT_CHK,
        S_PT_RD,
        S_PT_WR,
        S_RD_RD,
        S_RD_DAT,
        S_CL_SEEN,
        S_SC_RD,
        S_SC_DAT,
        S_RY_R,
        S_RY_SQ,
        S_RY_ACC,
        S_RY_SQS,
        S_RY_SQRT,
        S_RY_DVS,
        S_RY_DIV,
        S_RY_STP,
        S_RY_SET,
        S_ST_CHK,
        S_ST_RD,
        S_ST_WR,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// File: hdl/voc_ram.sv
// ----------------------------------------------------------------------------
// voc_ram - single-clock RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module voc_ram #(
    parameter int W     = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/voc_isqrt.sv
// ----------------------------------------------------------------------------
// voc_isqrt - iterative integer square root
// Floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module voc_isqrt #(
    parameter int W = 52
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [W-1:0]     i_op,
    output logic                  o_done,
    output logic      [W/2-1:0]   o_root
);

    localparam int RW = W / 2;
    localparam int CW = $clog2(RW + 1);

    logic [W-1:0]  r_op;
    logic [RW:0]   r_rem;
    logic [RW-1:0] r_root;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [RW+2:0] rem_sh;
    logic [RW+2:0] trial;
    logic [RW+2:0] diff;
    logic          take;

    assign rem_sh = {r_rem, r_op[W-1:W-2]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign diff   = rem_sh - trial;
    assign take   = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(RW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op   <= i_op;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_op <= {r_op[W-3:0], 2'b00};
            if (take) begin
                r_rem  <= diff[RW:0];
                r_root <= {r_root[RW-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh[RW:0];
                r_root <= {r_root[RW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

// File: hdl/voc_div.sv
// ----------------------------------------------------------------------------
// voc_div - iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module voc_div #(
    parameter int NW = 40,
    parameter int DW = 24
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_done,
    output logic      [NW-1:0] o_quo
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_num;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_den;
    logic [DW-1:0] r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   rem_sh;
    logic [DW:0]   diff;
    logic          take;

    assign rem_sh = {r_rem, r_num[NW-1]};
    assign diff   = rem_sh - {1'b0, r_den};
    assign take   = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], 1'b0};
            r_quo <= {r_quo[NW-2:0], take};
            r_rem <= take ? diff[DW-1:0] : rem_sh[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

// File: hdl/voxel_occupancy_free_space.sv
// ----------------------------------------------------------------------------
// voxel_occupancy_free_space - voxel occupancy and free-space evidence grid
// Point binning, free-space ray casting, voxel readback and grid clear.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_in_valid / o_in_ready) carries one command transaction:
//    mode 0 bins a point, 1 casts free-space rays, 2 reads a voxel, 3 clears.
//  - Output channel (o_out_valid / i_out_ready) returns exactly one result
//    transaction per command. The result sits in an output register, so the
//    next command is taken while the previous result still waits.
//  - Commands are handled one at a time. A clear sweeps every entry of both
//    RAMs. A cast runs one clear sweep of the seen grid, a scan read of each
//    voxel in use and, per occupied voxel, a square root and three
//    divisions, then a ray walk: a step outside the grid in use is only
//    checked, a step inside it does a read-modify-write of the seen count.
//  - Both counts live in single-port-read RAMs; every update is a read,
//    then a write back in the next cycle, so accesses never overlap.
//  - After reset the block sweeps both RAMs to zero, one entry per cycle
//    (131072 entries with the default grid); o_in_ready stays low until done.
//    APB writes are taken at any time, pready is tied high.
//  - A stalled receiver holds the result; the engine parks in its done state
//    until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module voxel_occupancy_free_space #(
    parameter int GRID_X = voc_pkg::GRID_X_DEF,
    parameter int GRID_Y = voc_pkg::GRID_Y_DEF,
    parameter int GRID_Z = voc_pkg::GRID_Z_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [4:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready,
    // command channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [1:0]           i_mode,
    input  wire logic signed [23:0]   i_coord_x,
    input  wire logic signed [23:0]   i_coord_y,
    input  wire logic signed [23:0]   i_coord_z,
    input  wire logic [5:0]           i_index_x,
    input  wire logic [5:0]           i_index_y,
    input  wire logic [4:0]           i_index_z,
    // result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [15:0]               o_voxel_points,
    output logic [31:0]               o_voxel_seen,
    output logic                      o_accepted
);

    localparam int DEPTH = GRID_X * GRID_Y * GRID_Z;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = voc_pkg::PNT_W;
    localparam int SW    = voc_pkg::SEEN_W;
    localparam int POSW  = voc_pkg::POS_W;
    localparam int NUMW  = voc_pkg::NUM_W;
    localparam int LENW  = voc_pkg::LEN_W;
    localparam int UW    = voc_pkg::UNIT_W;
    localparam int STW   = voc_pkg::STP_W;
    localparam logic signed [33:0] CMAX = 34'(voc_pkg::COMP_MAX);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic signed [23:0] r_min [3];
    logic [7:0]         r_vpm;
    logic [6:0]         r_size_x;
    logic [6:0]         r_size_y;
    logic [5:0]         r_size_z;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        case (voc_pkg::t_reg'(paddr[4:2]))
            voc_pkg::REG_MIN_X:  prdata = {8'd0, r_min[0]};
            voc_pkg::REG_MIN_Y:  prdata = {8'd0, r_min[1]};
            voc_pkg::REG_MIN_Z:  prdata = {8'd0, r_min[2]};
            voc_pkg::REG_VPM:    prdata = {24'd0, r_vpm};
            voc_pkg::REG_SIZE_X: prdata = {25'd0, r_size_x};
            voc_pkg::REG_SIZE_Y: prdata = {25'd0, r_size_y};
            voc_pkg::REG_SIZE_Z: prdata = {26'd0, r_size_z};
            default:             prdata = '0;
        endcase
    end

    // voxels in use per axis: min(size, grid)
    logic [6:0] s_eff [3];
    assign s_eff[0] = (32'(r_size_x) < GRID_X) ? r_size_x : 7'(GRID_X);
    assign s_eff[1] = (32'(r_size_y) < GRID_Y) ? r_size_y : 7'(GRID_Y);
    assign s_eff[2] = (32'(r_size_z) < GRID_Z) ? {1'b0, r_size_z} : 7'(GRID_Z);

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    voc_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_clr;
    logic            r_clr_res;
    logic            r_out_valid;
    logic [PW-1:0]   r_out_p;
    logic [SW-1:0]   r_out_s;
    logic            r_out_a;

    // datapath registers
    logic signed [24:0]   r_dd  [3];   // point - minimum
    logic signed [33:0]   r_dq  [3];   // times resolution
    logic signed [32:0]   r_pm  [3];   // minimum times resolution
    logic [6:0]           r_c   [3];   // target voxel
    logic [6:0]           r_s   [3];   // scan voxel
    logic [PW-1:0]        r_cnt;
    logic signed [24:0]   r_r   [3];   // ray components
    logic [49:0]          r_sq;
    logic [voc_pkg::SUM_W-1:0] r_sum;
    logic [1:0]           r_ax;
    logic [LENW-1:0]      r_len;
    logic signed [UW-1:0] r_u   [3];
    logic [39:0]          r_stp;
    logic [STW-1:0]       r_steps;
    logic [STW-1:0]       r_a;
    logic signed [POSW-1:0] r_pos [3];
    logic [PW-1:0]        r_rp;
    logic [SW-1:0]        r_rs;
    logic                 r_ra;

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    logic          pt_we, sn_we, pt_re, sn_re;
    logic [AW-1:0] pt_waddr, pt_raddr, sn_waddr;
    logic [PW-1:0] pt_wdata, pt_rdata;
    logic [SW-1:0] sn_wdata, sn_rdata;
    logic          wr_clr, rd_scan;
    logic [31:0]   cell_c, cell_s;

    assign cell_c = (32'(r_c[2]) * 32'(GRID_Y) + 32'(r_c[1])) * 32'(GRID_X) + 32'(r_c[0]);
    assign cell_s = (32'(r_s[2]) * 32'(GRID_Y) + 32'(r_s[1])) * 32'(GRID_X) + 32'(r_s[0]);

    assign pt_waddr = wr_clr ? r_clr : cell_c[AW-1:0];
    assign sn_waddr = wr_clr ? r_clr : cell_c[AW-1:0];
    assign pt_raddr = rd_scan ? cell_s[AW-1:0] : cell_c[AW-1:0];

    voc_ram #(.W(PW), .DEPTH(DEPTH), .AW(AW)) u_pt_ram (
        .i_clk   (i_clk),
        .i_we    (pt_we),
        .i_waddr (pt_waddr),
        .i_wdata (pt_wdata),
        .i_re    (pt_re),
        .i_raddr (pt_raddr),
        .o_rdata (pt_rdata)
    );

    voc_ram #(.W(SW), .DEPTH(DEPTH), .AW(AW)) u_sn_ram (
        .i_clk   (i_clk),
        .i_we    (sn_we),
        .i_waddr (sn_waddr),
        .i_wdata (sn_wdata),
        .i_re    (sn_re),
        .i_raddr (cell_c[AW-1:0]),
        .o_rdata (sn_rdata)
    );

    // ------------------------------------------------------------------
    // shared iterative units for ray setup
    // ------------------------------------------------------------------
    logic                 sq_start, sq_done;
    logic [25:0]          sq_root;
    logic                 dv_start, dv_done;
    logic [NUMW-1:0]      dv_quo;
    logic [24:0]          mag;

    assign mag = r_r[r_ax][24] ? 25'(-r_r[r_ax]) : 25'(r_r[r_ax]);

    voc_isqrt #(.W(voc_pkg::SUM_W)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_op    (r_sum),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    voc_div #(.NW(NUMW), .DW(LENW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dv_start),
        .i_num   ({mag[23:0], 16'd0}),
        .i_den   (r_len),
        .o_done  (dv_done),
        .o_quo   (dv_quo)
    );

    // ------------------------------------------------------------------
    // combinational datapath
    // ------------------------------------------------------------------
    logic                   in_fire;
    logic                   clr_last;
    logic                   vox_last;
    logic                   step_last;
    logic signed [33:0]     dq_w  [3];
    logic signed [32:0]     pm_w  [3];
    logic signed [33:0]     qb    [3];
    logic signed [33:0]     tq    [3];
    logic [2:0]             pt_in;
    logic signed [33:0]     cr    [3];
    logic signed [24:0]     rc    [3];
    logic signed [49:0]     sq_w;
    logic [LENW-1:0]        lw;
    logic signed [UW-1:0]   uc;
    logic [STW-1:0]         stop;
    logic signed [POSW-1:0] org   [3];
    logic signed [POSW-1:0] hp    [3];
    logic [2:0]             st_in;
    logic [2:0]             rd_in;
    logic [PW-1:0]          pt_inc;
    logic [SW:0]            sn_sum;

    assign in_fire   = i_in_valid && o_in_ready;
    assign clr_last  = (r_clr == AW'(DEPTH - 1));
    assign vox_last  = (r_s[0] == s_eff[0] - 7'd1) && (r_s[1] == s_eff[1] - 7'd1)
                    && (r_s[2] == s_eff[2] - 7'd1);
    assign step_last = (r_a == r_steps - 1'b1);
    assign sq_w      = r_r[r_ax] * r_r[r_ax];
    assign lw        = (sq_root > 26'(voc_pkg::COMP_MAX)) ? '1 : sq_root[LENW-1:0];
    assign stop      = r_stp[39:24];
    assign pt_inc    = (pt_rdata == '1) ? pt_rdata : pt_rdata + 1'b1;
    assign sn_sum    = {1'b0, sn_rdata} + (SW + 1)'(r_cnt);

    always_comb begin
        if (r_r[r_ax][24]) begin
            uc = (dv_quo > NUMW'(131072)) ? UW'(-131072) : UW'(-dv_quo);
        end else begin
            uc = (dv_quo > NUMW'(131071)) ? UW'(131071) : UW'(dv_quo);
        end
    end

    always_comb begin
        for (int d = 0; d < 3; d++) begin
            dq_w[d]  = r_dd[d] * $signed({1'b0, r_vpm});
            pm_w[d]  = r_min[d] * $signed({1'b0, r_vpm});
            // truncate toward zero: bias negatives before the shift
            qb[d]    = r_dq[d] + $signed({26'd0, {8{r_dq[d][33]}}});
            tq[d]    = qb[d] >>> 8;
            pt_in[d] = !tq[d][33] && (tq[d] < $signed({27'd0, s_eff[d]}));
            cr[d]    = $signed({19'd0, r_s[d], 8'd0}) + $signed({r_pm[d][32], r_pm[d]});
            if (cr[d] > CMAX) begin
                rc[d] = 25'(CMAX);
            end else if (cr[d] < -CMAX) begin
                rc[d] = 25'(-CMAX);
            end else begin
                rc[d] = 25'(cr[d]);
            end
            org[d]   = -$signed({r_pm[d][32], r_pm[d], 8'd0});
            hp[d]    = r_pos[d] >>> 16;
            st_in[d] = !hp[d][POSW-1] && (hp[d] < $signed({35'd0, s_eff[d]}));
            rd_in[d] = (r_c[d] < s_eff[d]);
        end
    end

    // ------------------------------------------------------------------
    // control FSM
    // ------------------------------------------------------------------
    logic          res_ld, res_a, adv_vox, adv_step, out_ld;
    logic [PW-1:0] res_p;
    logic [SW-1:0] res_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= voc_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        pt_we    = 1'b0;
        sn_we    = 1'b0;
        pt_re    = 1'b0;
        sn_re    = 1'b0;
        pt_wdata = '0;
        sn_wdata = '0;
        wr_clr   = 1'b0;
        rd_scan  = 1'b0;
        res_ld   = 1'b0;
        res_p    = '0;
        res_s    = '0;
        res_a    = 1'b0;
        adv_vox  = 1'b0;
        adv_step = 1'b0;
        sq_start = 1'b0;
        dv_start = 1'b0;
        out_ld   = 1'b0;
        case (r_state)
            voc_pkg::S_CLEAR: begin
                pt_we  = 1'b1;
                sn_we  = 1'b1;
                wr_clr = 1'b1;
                if (clr_last) begin
                    if (r_clr_res) begin
                        res_ld  = 1'b1;
                        res_a   = 1'b1;
                        n_state = voc_pkg::S_DONE;
                    end else begin
                        n_state = voc_pkg::S_IDLE;
                    end
                end
            end
            voc_pkg::S_IDLE: begin
                if (in_fire) begin
                    case (voc_pkg::t_mode'(i_mode))
                        voc_pkg::MODE_POINT: n_state = voc_pkg::S_PT_MUL;
                        voc_pkg::MODE_CAST:  n_state = voc_pkg::S_CL_SEEN;
                        voc_pkg::MODE_READ:  n_state = voc_pkg::S_RD_RD;
                        default:             n_state = voc_pkg::S_CLEAR;
                    endcase
                end
            end
            voc_pkg::S_PT_MUL: n_state = voc_pkg::S_PT_CHK;
            voc_pkg::S_PT_CHK: begin
                if (&pt_in) begin
                    n_state = voc_pkg::S_PT_RD;
                end else begin
                    res_ld  = 1'b1;
                    n_state = voc_pkg::S_DONE;
                end
            end
            voc_pkg::S_PT_RD: begin
                pt_re   = 1'b1;
                sn_re   = 1'b1;
                n_state = voc_pkg::S_PT_WR;
            end
            voc_pkg::S_PT_WR: begin
                pt_we    = 1'b1;
                pt_wdata = pt_inc;
                res_ld   = 1'b1;
                res_p    = pt_inc;
                res_s    = sn_rdata;
                res_a    = 1'b1;
                n_state  = voc_pkg::S_DONE;
            end
            voc_pkg::S_RD_RD: begin
                if (&rd_in) begin
                    pt_re   = 1'b1;
                    sn_re   = 1'b1;
                    n_state = voc_pkg::S_RD_DAT;
                end else begin
                    res_ld  = 1'b1;
                    n_state = voc_pkg::S_DONE;
                end
            end
            voc_pkg::S_RD_DAT: begin
                res_ld  = 1'b1;
                res_p   = pt_rdata;
                res_s   = sn_rdata;
                res_a   = 1'b1;
                n_state = voc_pkg::S_DONE;
            end
            voc_pkg::S_CL_SEEN: begin
                sn_we  = 1'b1;
                wr_clr = 1'b1;
                if (clr_last) begin
                    if ((s_eff[0] == '0) || (s_eff[1] == '0) || (s_eff[2] == '0)) begin
                        res_ld  = 1'b1;
                        res_a   = 1'b1;
                        n_state = voc_pkg::S_DONE;
                    end else begin
                        n_state = voc_pkg::S_SC_RD;
                    end
                end
            end
            voc_pkg::S_SC_RD: begin
                pt_re   = 1'b1;
                rd_scan = 1'b1;
                n_state = voc_pkg::S_SC_DAT;
            end
            voc_pkg::S_SC_DAT: begin
                if (pt_rdata == '0) begin
                    adv_vox = 1'b1;
                end else begin
                    n_state = voc_pkg::S_RY_R;
                end
            end
            voc_pkg::S_RY_R:   n_state = voc_pkg::S_RY_SQ;
            voc_pkg::S_RY_SQ:  n_state = voc_pkg::S_RY_ACC;
            voc_pkg::S_RY_ACC: begin
                n_state = (r_ax == 2'd2) ? voc_pkg::S_RY_SQS : voc_pkg::S_RY_SQ;
            end
            voc_pkg::S_RY_SQS: begin
                sq_start = 1'b1;
                n_state  = voc_pkg::S_RY_SQRT;
            end
            voc_pkg::S_RY_SQRT: begin
                if (sq_done) begin
                    if (lw == '0) begin
                        adv_vox = 1'b1;
                    end else begin
                        n_state = voc_pkg::S_RY_DVS;
                    end
                end
            end
            voc_pkg::S_RY_DVS: begin
                dv_start = 1'b1;
                n_state  = voc_pkg::S_RY_DIV;
            end
            voc_pkg::S_RY_DIV: begin
                if (dv_done) begin
                    n_state = (r_ax == 2'd2) ? voc_pkg::S_RY_STP : voc_pkg::S_RY_DVS;
                end
            end
            voc_pkg::S_RY_STP: n_state = voc_pkg::S_RY_SET;
            voc_pkg::S_RY_SET: begin
                if (stop <= voc_pkg::STEP_BIAS) begin
                    adv_vox = 1'b1;
                end else begin
                    n_state = voc_pkg::S_ST_CHK;
                end
            end
            voc_pkg::S_ST_CHK: begin
                if (&st_in) begin
                    n_state = voc_pkg::S_ST_RD;
                end else begin
                    adv_step = 1'b1;
                end
            end
            voc_pkg::S_ST_RD: begin
                sn_re   = 1'b1;
                n_state = voc_pkg::S_ST_WR;
            end
            voc_pkg::S_ST_WR: begin
                sn_we    = 1'b1;
                sn_wdata = sn_sum[SW] ? '1 : sn_sum[SW-1:0];
                adv_step = 1'b1;
            end
            voc_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    out_ld  = 1'b1;
                    n_state = voc_pkg::S_IDLE;
                end
            end
            default: n_state = voc_pkg::S_IDLE;
        endcase

        // end of a ray walk moves the scan on
        if (adv_step) begin
            if (step_last) begin
                adv_vox = 1'b1;
            end else begin
                n_state = voc_pkg::S_ST_CHK;
            end
        end
        if (adv_vox) begin
            if (vox_last) begin
                res_ld  = 1'b1;
                res_a   = 1'b1;
                n_state = voc_pkg::S_DONE;
            end else begin
                n_state = voc_pkg::S_SC_RD;
            end
        end
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min[0]    <= '0;
            r_min[1]    <= '0;
            r_min[2]    <= '0;
            r_vpm       <= voc_pkg::VPM_RST;
            r_size_x    <= voc_pkg::SIZE_X_RST;
            r_size_y    <= voc_pkg::SIZE_Y_RST;
            r_size_z    <= voc_pkg::SIZE_Z_RST;
            r_clr       <= '0;
            r_clr_res   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (voc_pkg::t_reg'(paddr[4:2]))
                    voc_pkg::REG_MIN_X:  r_min[0] <= pwdata[23:0];
                    voc_pkg::REG_MIN_Y:  r_min[1] <= pwdata[23:0];
                    voc_pkg::REG_MIN_Z:  r_min[2] <= pwdata[23:0];
                    voc_pkg::REG_VPM:    r_vpm    <= pwdata[7:0];
                    voc_pkg::REG_SIZE_X: r_size_x <= pwdata[6:0];
                    voc_pkg::REG_SIZE_Y: r_size_y <= pwdata[6:0];
                    voc_pkg::REG_SIZE_Z: r_size_z <= pwdata[5:0];
                    default: ;
                endcase
            end
            if (wr_clr) begin
                r_clr <= clr_last ? '0 : r_clr + 1'b1;
            end
            if (in_fire) begin
                r_clr_res <= (voc_pkg::t_mode'(i_mode) == voc_pkg::MODE_CLEAR);
            end
            if (out_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_state == voc_pkg::S_IDLE) begin
            for (int d = 0; d < 3; d++) begin
                r_pm[d] <= pm_w[d];
            end
        end
        if (in_fire) begin
            r_dd[0] <= {i_coord_x[23], i_coord_x} - {r_min[0][23], r_min[0]};
            r_dd[1] <= {i_coord_y[23], i_coord_y} - {r_min[1][23], r_min[1]};
            r_dd[2] <= {i_coord_z[23], i_coord_z} - {r_min[2][23], r_min[2]};
            r_c[0]  <= {1'b0, i_index_x};
            r_c[1]  <= {1'b0, i_index_y};
            r_c[2]  <= {2'b00, i_index_z};
        end
        if (r_state == voc_pkg::S_PT_MUL) begin
            for (int d = 0; d < 3; d++) begin
                r_dq[d] <= dq_w[d];
            end
        end
        if (r_state == voc_pkg::S_PT_CHK) begin
            for (int d = 0; d < 3; d++) begin
                r_c[d] <= tq[d][6:0];
            end
        end
        if (r_state == voc_pkg::S_CL_SEEN) begin
            for (int d = 0; d < 3; d++) begin
                r_s[d] <= '0;
            end
        end
        if (r_state == voc_pkg::S_SC_DAT) begin
            r_cnt <= pt_rdata;
        end
        if (r_state == voc_pkg::S_RY_R) begin
            for (int d = 0; d < 3; d++) begin
                r_r[d] <= rc[d];
            end
            r_sum <= '0;
            r_ax  <= '0;
        end
        if (r_state == voc_pkg::S_RY_SQ) begin
            r_sq <= 50'(sq_w);
        end
        if (r_state == voc_pkg::S_RY_ACC) begin
            r_sum <= r_sum + {2'b00, r_sq};
            r_ax  <= (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
        end
        if ((r_state == voc_pkg::S_RY_SQRT) && sq_done) begin
            r_len <= lw;
            r_ax  <= '0;
        end
        if ((r_state == voc_pkg::S_RY_DIV) && dv_done) begin
            r_u[r_ax] <= uc;
            r_ax      <= r_ax + 2'd1;
        end
        if (r_state == voc_pkg::S_RY_STP) begin
            r_stp <= 40'(r_len) * 40'(voc_pkg::FRAC_085);
        end
        if (r_state == voc_pkg::S_RY_SET) begin
            r_steps <= stop - voc_pkg::STEP_BIAS;
            r_a     <= '0;
            for (int d = 0; d < 3; d++) begin
                r_pos[d] <= org[d];
            end
        end
        if ((r_state == voc_pkg::S_ST_CHK) && (&st_in)) begin
            for (int d = 0; d < 3; d++) begin
                r_c[d] <= hp[d][6:0];
            end
        end
        if (adv_step) begin
            r_a <= r_a + 1'b1;
            for (int d = 0; d < 3; d++) begin
                r_pos[d] <= r_pos[d] + {{(POSW - UW){r_u[d][UW-1]}}, r_u[d]};
            end
        end
        // scan order: z outermost, then x, y innermost
        if (adv_vox) begin
            if (r_s[1] == s_eff[1] - 7'd1) begin
                r_s[1] <= '0;
                if (r_s[0] == s_eff[0] - 7'd1) begin
                    r_s[0] <= '0;
                    r_s[2] <= r_s[2] + 7'd1;
                end else begin
                    r_s[0] <= r_s[0] + 7'd1;
                end
            end else begin
                r_s[1] <= r_s[1] + 7'd1;
            end
        end
        if (res_ld) begin
            r_rp <= res_p;
            r_rs <= res_s;
            r_ra <= res_a;
        end
        if (out_ld) begin
            r_out_p <= r_rp;
            r_out_s <= r_rs;
            r_out_a <= r_ra;
        end
    end

    assign o_in_ready     = (r_state == voc_pkg::S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_voxel_points = r_out_p;
    assign o_voxel_seen   = r_out_s;
    assign o_accepted     = r_out_a;

`ifndef ASSERT_OFF
    a_rmw_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == voc_pkg::S_ST_WR) |-> $past(r_state == voc_pkg::S_ST_RD))
        else $error("seen write without its read");

    a_cmd_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != voc_pkg::S_IDLE))
        else $error("command accepted but engine stayed idle");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ld |-> (r_state == voc_pkg::S_DONE))
        else $error("result loaded outside done state");

    a_no_double_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pt_we && !wr_clr) |-> !sn_we)
        else $error("both grids written by a point update");
`endif

endmodule

`default_nettype wire
